// File: sv/piecewise_linear_table_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Piecewise linear table interpolator - assertion macros
// Clocked on clk_i; rst_ni active low.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH

// Checked outside reset only
`define PLTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included
`define PLTI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 32;
  localparam int OFF_W   = 24;
  localparam int PROD_W  = POS_W + OFF_W;
  localparam int DCNT_W  = $clog2(OFF_W);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_SPAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [OFF_W-1:0] off;
    logic                    ok;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/plti_mem.sv
// ----------------------------------------------------------------------------
// plti_mem
// Single port write, single port read RAM with registered read data.
// ----------------------------------------------------------------------------
module plti_mem #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/plti_div.sv
// ----------------------------------------------------------------------------
// plti_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// OFF_W bits, so the upper dividend bits seed the remainder directly.
// ----------------------------------------------------------------------------
module plti_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [plti_pkg::PROD_W-1:0]    dividend_i,
  input  logic [plti_pkg::POS_W-1:0]     divisor_i,
  output logic [plti_pkg::OFF_W-1:0]     quotient_o,
  output logic                           done_o
);

  logic [plti_pkg::POS_W-1:0]  rem_q, rem_d;
  logic [plti_pkg::OFF_W-1:0]  low_q, low_d;
  logic [plti_pkg::POS_W-1:0]  div_q, div_d;
  logic [plti_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [plti_pkg::POS_W:0]    trial;
  logic [plti_pkg::POS_W:0]    diff;

  assign trial = {rem_q, low_q[plti_pkg::OFF_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = dividend_i[plti_pkg::PROD_W-1:plti_pkg::OFF_W];
      low_d  = dividend_i[plti_pkg::OFF_W-1:0];
      div_d  = divisor_i;
      cnt_d  = plti_pkg::DCNT_W'(plti_pkg::OFF_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // trial stays below twice the divisor, so one subtract settles the bit
      if (!diff[plti_pkg::POS_W]) begin
        rem_d = diff[plti_pkg::POS_W-1:0];
        low_d = {low_q[plti_pkg::OFF_W-2:0], 1'b1};
      end else begin
        rem_d = trial[plti_pkg::POS_W-1:0];
        low_d = {low_q[plti_pkg::OFF_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    div_q <= div_d;
  end

  assign quotient_o = low_q;
  assign done_o     = done_q;

endmodule

// File: sv/piecewise_linear_table_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Sample table with clear, append and linear interpolation lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries kind_i, position_i,
//   offset_value_i and offset_ok_i. Clear and append give no result; an
//   append to a full table is dropped. A query gives exactly one result
//   transaction on the output channel (out_valid_o / out_ready_i). A query
//   is answered from the first entry or else after a walk over the table.
//   The walk reads one table entry per cycle from the single RAM read port,
//   and the division runs on the restoring divider.
//   One item is in flight at a time; in_ready_o is high only while idle.
//   Results sit in an output register, so the next item is taken while a
//   result still waits; a stalled receiver holds back only the next query's
//   hand-off into that register.
//   Reset empties the table (count to zero); the RAM contents need no clear.
//   Units are 1/1024 m; result_offset_o is 0 whenever result_valid_o is 0.
// ----------------------------------------------------------------------------
`include "piecewise_linear_table_interpolator_macros.svh"

module piecewise_linear_table_interpolator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            kind_i,
  input  logic signed [plti_pkg::POS_W-1:0]     position_i,
  input  logic signed [plti_pkg::OFF_W-1:0]     offset_value_i,
  input  logic                                  offset_ok_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [plti_pkg::OFF_W-1:0]     result_offset_o,
  output logic                                  result_valid_o
);

  plti_pkg::state_e state_q, state_d;

  logic [plti_pkg::CNT_W-1:0]          entry_cnt_q, entry_cnt_d;
  logic [plti_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic signed [plti_pkg::POS_W-1:0]   pos_q, pos_d;
  plti_pkg::entry_t                    prev_q, prev_d;
  plti_pkg::entry_t                    cur_q, cur_d;
  logic [plti_pkg::POS_W-1:0]          span_q, span_d;
  logic [plti_pkg::POS_W-1:0]          dist_q, dist_d;
  logic [plti_pkg::OFF_W-1:0]          mag_q, mag_d;
  logic                                neg_q, neg_d;
  logic signed [plti_pkg::OFF_W-1:0]   res_off_q, res_off_d;
  logic                                res_ok_q, res_ok_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [plti_pkg::OFF_W-1:0]   out_off_q, out_off_d;
  logic                                out_ok_q, out_ok_d;

  logic                                in_fire;
  logic                                mem_we;
  plti_pkg::entry_t                    wr_entry;
  plti_pkg::entry_t                    rd_entry;
  logic [plti_pkg::ENTRY_W-1:0]        rd_data;
  logic                                div_start;
  logic                                div_done;
  logic [plti_pkg::OFF_W-1:0]          quotient;
  logic [plti_pkg::PROD_W-1:0]         product;
  logic                                out_free;
  logic                                at_last;
  logic signed [plti_pkg::POS_W:0]     span_w;
  logic signed [plti_pkg::POS_W:0]     dist_w;
  logic signed [plti_pkg::OFF_W:0]     diff_w;
  logic signed [plti_pkg::OFF_W:0]     step_w;
  logic signed [plti_pkg::OFF_W:0]     sum_w;

  assign in_ready_o = (state_q == plti_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_entry   = plti_pkg::entry_t'(rd_data);
  assign at_last    = ({1'b0, idx_q} == (entry_cnt_q - 1'b1));

  assign span_w = {cur_q.pos[plti_pkg::POS_W-1], cur_q.pos}
                - {prev_q.pos[plti_pkg::POS_W-1], prev_q.pos};
  assign dist_w = {pos_q[plti_pkg::POS_W-1], pos_q}
                - {prev_q.pos[plti_pkg::POS_W-1], prev_q.pos};
  assign diff_w = {cur_q.off[plti_pkg::OFF_W-1], cur_q.off}
                - {prev_q.off[plti_pkg::OFF_W-1], prev_q.off};
  assign step_w = neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
  assign sum_w  = {prev_q.off[plti_pkg::OFF_W-1], prev_q.off} + step_w;

  assign product  = plti_pkg::PROD_W'(mag_q) * plti_pkg::PROD_W'(dist_q);

  assign wr_entry.pos = position_i;
  assign wr_entry.off = offset_value_i;
  assign wr_entry.ok  = offset_ok_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plti_pkg::ST_IDLE: begin
        if (in_fire && (kind_i == plti_pkg::KIND_QUERY)) begin
          state_d = (entry_cnt_q == '0) ? plti_pkg::ST_DONE : plti_pkg::ST_FIRST;
        end
      end
      plti_pkg::ST_FIRST: begin
        if ((entry_cnt_q == plti_pkg::CNT_W'(1)) || (pos_q <= rd_entry.pos)) begin
          state_d = plti_pkg::ST_DONE;
        end else begin
          state_d = plti_pkg::ST_SCAN;
        end
      end
      plti_pkg::ST_SCAN: begin
        if (pos_q <= rd_entry.pos) begin
          state_d = (prev_q.ok && rd_entry.ok) ? plti_pkg::ST_SPAN : plti_pkg::ST_DONE;
        end else if (at_last) begin
          state_d = plti_pkg::ST_DONE;
        end
      end
      plti_pkg::ST_SPAN: begin
        if (span_w[plti_pkg::POS_W] || (span_w == '0)) begin
          state_d = plti_pkg::ST_DONE;
        end else begin
          state_d = plti_pkg::ST_MUL;
        end
      end
      plti_pkg::ST_MUL: state_d = plti_pkg::ST_DIV;
      plti_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = plti_pkg::ST_DONE;
        end
      end
      plti_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = plti_pkg::ST_IDLE;
        end
      end
      default: state_d = plti_pkg::ST_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    entry_cnt_d = entry_cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    span_d      = span_q;
    dist_d      = dist_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    res_off_d   = res_off_q;
    res_ok_d    = res_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_off_d   = out_off_q;
    out_ok_d    = out_ok_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      plti_pkg::ST_IDLE: begin
        idx_d     = '0;
        res_off_d = '0;
        res_ok_d  = 1'b0;
        if (in_fire) begin
          case (kind_i)
            plti_pkg::KIND_CLEAR: entry_cnt_d = '0;
            plti_pkg::KIND_APPEND: begin
              if (entry_cnt_q < plti_pkg::DEPTH_CNT) begin
                mem_we      = 1'b1;
                entry_cnt_d = entry_cnt_q + 1'b1;
              end
            end
            plti_pkg::KIND_QUERY: pos_d = position_i;
            default: ;
          endcase
        end
      end
      plti_pkg::ST_FIRST: begin
        if ((entry_cnt_q == plti_pkg::CNT_W'(1)) || (pos_q <= rd_entry.pos)) begin
          res_off_d = rd_entry.ok ? rd_entry.off : '0;
          res_ok_d  = rd_entry.ok;
        end else begin
          prev_d = rd_entry;
          idx_d  = plti_pkg::ADDR_W'(1);
        end
      end
      plti_pkg::ST_SCAN: begin
        // Reaching entry i means the position lies beyond entry i-1
        if (pos_q <= rd_entry.pos) begin
          cur_d = rd_entry;
        end else if (at_last) begin
          res_off_d = rd_entry.ok ? rd_entry.off : '0;
          res_ok_d  = rd_entry.ok;
        end else begin
          prev_d = rd_entry;
          idx_d  = idx_q + 1'b1;
        end
      end
      plti_pkg::ST_SPAN: begin
        if (span_w[plti_pkg::POS_W] || (span_w == '0)) begin
          res_off_d = cur_q.off;
          res_ok_d  = 1'b1;
        end else begin
          // 0 < dist <= span here, so no clamp is needed
          span_d = span_w[plti_pkg::POS_W-1:0];
          dist_d = dist_w[plti_pkg::POS_W-1:0];
          neg_d  = diff_w[plti_pkg::OFF_W];
          mag_d  = diff_w[plti_pkg::OFF_W] ? plti_pkg::OFF_W'(-diff_w)
                                           : diff_w[plti_pkg::OFF_W-1:0];
        end
      end
      plti_pkg::ST_MUL: div_start = 1'b1;
      plti_pkg::ST_DIV: begin
        if (div_done) begin
          res_off_d = sum_w[plti_pkg::OFF_W-1:0];
          res_ok_d  = 1'b1;
        end
      end
      plti_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_ok_d    = res_ok_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plti_pkg::ST_IDLE;
      entry_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      entry_cnt_q <= entry_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    span_q    <= span_d;
    dist_q    <= dist_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    res_off_q <= res_off_d;
    res_ok_q  <= res_ok_d;
    out_off_q <= out_off_d;
    out_ok_q  <= out_ok_d;
  end

  plti_mem #(
    .DATA_W (plti_pkg::ENTRY_W),
    .DEPTH  (plti_pkg::DEPTH),
    .ADDR_W (plti_pkg::ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (entry_cnt_q[plti_pkg::ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  plti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (span_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign out_valid_o     = out_valid_q;
  assign result_offset_o = out_off_q;
  assign result_valid_o  = out_ok_q;

  // the count is unknown until the first edge in reset
  `PLTI_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (entry_cnt_q <= plti_pkg::DEPTH_CNT), "entry count over depth")
  `PLTI_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == plti_pkg::ST_DONE), "result without finished query")
  `PLTI_ASSERT(a_invalid_zero, (out_valid_q && !out_ok_q) |-> (out_off_q == '0), "invalid result with nonzero offset")
  `PLTI_ASSERT(a_div_in_div, div_done |-> (state_q == plti_pkg::ST_DIV), "divider finished outside divide phase")
  `PLTI_ASSERT(a_scan_in_range, (state_q == plti_pkg::ST_SCAN) |-> ({1'b0, idx_q} < entry_cnt_q), "scan beyond filled entries")

endmodule

// File: test/piecewise_linear_table_interpolator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Piecewise linear table interpolator - self-checking testbench
// Drives clear, append and query transactions with random idling on both
// channels. A directed table covers the extremes and the corner cases, then
// random table builds and lookups follow. Every query answer is checked
// against a local model of the sample table or a directed expected value.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_test;

  localparam int     ITEMS         = 1950;
  localparam int     CALM_ITEMS    = 200;
  localparam int     LONG_HOLD     = 600;
  localparam int     SETTLE_CYCLES = 400;
  localparam longint CYCLE_LIMIT   = 3_000_000;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [plti_pkg::POS_W-1:0] POS_MIN =
    {1'b1, {(plti_pkg::POS_W-1){1'b0}}};
  localparam logic signed [plti_pkg::POS_W-1:0] POS_MAX =
    {1'b0, {(plti_pkg::POS_W-1){1'b1}}};
  localparam logic signed [plti_pkg::OFF_W-1:0] OFF_MIN =
    {1'b1, {(plti_pkg::OFF_W-1){1'b0}}};
  localparam logic signed [plti_pkg::OFF_W-1:0] OFF_MAX =
    {1'b0, {(plti_pkg::OFF_W-1){1'b1}}};

  typedef struct packed {
    logic signed [plti_pkg::OFF_W-1:0] off;
    logic                              ok;
  } answer_t;

  typedef struct {
    logic [1:0]                        kind;
    logic signed [plti_pkg::POS_W-1:0] pos;
    logic signed [plti_pkg::OFF_W-1:0] off;
    logic                              ok;
    bit                                use_fixed;
    answer_t                           fixed_ans;
  } step_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        kind_i         = plti_pkg::KIND_CLEAR;
  logic signed [plti_pkg::POS_W-1:0] position_i     = '0;
  logic signed [plti_pkg::OFF_W-1:0] offset_value_i = '0;
  logic                              offset_ok_i    = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic signed [plti_pkg::OFF_W-1:0] result_offset_o;
  logic                              result_valid_o;

  // local copy of the sample table
  logic signed [plti_pkg::POS_W-1:0] tbl_pos [plti_pkg::DEPTH];
  logic signed [plti_pkg::OFF_W-1:0] tbl_off [plti_pkg::DEPTH];
  logic                              tbl_ok  [plti_pkg::DEPTH];
  int                                tbl_count = 0;

  answer_t pending_answers[$];
  step_t   directed_steps[$];
  int      items_sent = 0;
  int      mismatches = 0;
  bit      calm       = 1'b0;
  bit      tx_gappy   = 1'b0;
  bit      hold_req   = 1'b0;
  bit      hold_done  = 1'b0;

  piecewise_linear_table_interpolator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .offset_value_i  (offset_value_i),
    .offset_ok_i     (offset_ok_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_offset_o (result_offset_o),
    .result_valid_o  (result_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic answer_t keep_if_valid(input logic signed [plti_pkg::OFF_W-1:0] off,
                                            input logic ok);
    answer_t ans;
    ans.ok  = ok;
    ans.off = ok ? off : '0;
    return ans;
  endfunction

  function automatic answer_t interpolate_at(input logic signed [plti_pkg::POS_W-1:0] q);
    answer_t ans;
    longint  p0, p1, o0, o1, span, d;
    int      i;
    ans = '0;
    if (tbl_count == 0) return ans;
    if (tbl_count == 1 || q <= tbl_pos[0]) return keep_if_valid(tbl_off[0], tbl_ok[0]);
    for (i = 1; i < tbl_count; i++) begin
      p1 = tbl_pos[i];
      if (longint'(q) <= p1) begin
        if (!tbl_ok[i-1] || !tbl_ok[i]) return ans;
        p0     = tbl_pos[i-1];
        o0     = tbl_off[i-1];
        o1     = tbl_off[i];
        span   = p1 - p0;
        ans.ok = 1'b1;
        if (span <= 0) begin
          ans.off = tbl_off[i];
          return ans;
        end
        d = longint'(q) - p0;
        if (d < 0) d = 0;
        if (d > span) d = span;
        // longint division truncates toward zero
        ans.off = plti_pkg::OFF_W'(o0 + (o1 - o0) * d / span);
        return ans;
      end
    end
    return keep_if_valid(tbl_off[tbl_count-1], tbl_ok[tbl_count-1]);
  endfunction

  // offers one transaction and updates the table model once it is taken
  task automatic send_item(input logic [1:0] kind,
                           input logic signed [plti_pkg::POS_W-1:0] pos,
                           input logic signed [plti_pkg::OFF_W-1:0] off, input logic ok,
                           input bit use_fixed = 1'b0, input answer_t fixed_ans = '0);
    if (!calm && tx_gappy && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    position_i     <= pos;
    offset_value_i <= off;
    offset_ok_i    <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (kind)
      plti_pkg::KIND_CLEAR: begin
        tbl_count = 0;
        items_sent++;
      end
      plti_pkg::KIND_APPEND: begin
        if (tbl_count < plti_pkg::DEPTH) begin
          tbl_pos[tbl_count] = pos;
          tbl_off[tbl_count] = off;
          tbl_ok[tbl_count]  = ok;
          tbl_count++;
          items_sent++;
        end
      end
      plti_pkg::KIND_QUERY: begin
        pending_answers.push_back(use_fixed ? fixed_ans : interpolate_at(pos));
        items_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic plan(input logic [1:0] kind, input logic signed [plti_pkg::POS_W-1:0] pos,
                      input logic signed [plti_pkg::OFF_W-1:0] off = '0,
                      input logic ok = 1'b0, input bit use_fixed = 1'b0,
                      input logic signed [plti_pkg::OFF_W-1:0] want_off = '0,
                      input logic want_ok = 1'b0);
    step_t s;
    s.kind          = kind;
    s.pos           = pos;
    s.off           = off;
    s.ok            = ok;
    s.use_fixed     = use_fixed;
    s.fixed_ans.off = want_off;
    s.fixed_ans.ok  = want_ok;
    directed_steps.push_back(s);
  endtask

  function automatic logic signed [plti_pkg::POS_W-1:0] pick_query_pos();
    longint lo, hi, v;
    int     k;
    if (tbl_count == 0) return plti_pkg::POS_W'($urandom);
    k  = $urandom_range(0, tbl_count - 1);
    lo = tbl_pos[0];
    hi = tbl_pos[tbl_count-1];
    case ($urandom_range(0, 5))
      0:       v = tbl_pos[k];
      1:       v = longint'(tbl_pos[k]) + longint'($urandom_range(0, 2)) - 1;
      2:       v = lo - longint'($urandom_range(0, 5000));
      3:       v = hi + longint'($urandom_range(0, 5000));
      4:       v = (hi > lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
      default: v = longint'($signed($urandom));
    endcase
    if (v > longint'(POS_MAX)) v = POS_MAX;
    if (v < longint'(POS_MIN)) v = POS_MIN;
    return plti_pkg::POS_W'(v);
  endfunction

  task automatic append_run(input int n, input bit ordered);
    longint                            cur;
    int                                gap_max;
    int                                i;
    logic signed [plti_pkg::OFF_W-1:0] off;
    if ($urandom_range(0, 3) == 0) cur = longint'($signed($urandom));
    else cur = longint'($urandom_range(0, 200000)) - 100000;
    case ($urandom_range(0, 3))
      0:       gap_max = 4;
      1:       gap_max = 2048;
      2:       gap_max = 1 << 20;
      default: gap_max = 32'h7fff_ffff;
    endcase
    off = plti_pkg::OFF_W'($urandom);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0)
        send_item(KIND_UNUSED, plti_pkg::POS_W'($urandom), plti_pkg::OFF_W'($urandom),
                  1'($urandom));
      if (!ordered) cur = longint'($signed($urandom));
      if ($urandom_range(0, 1) == 0) off = plti_pkg::OFF_W'($urandom);
      else off = plti_pkg::OFF_W'(longint'(off) + longint'($urandom_range(0, 64)) - 32);
      send_item(plti_pkg::KIND_APPEND, plti_pkg::POS_W'(cur), off,
                $urandom_range(0, 15) != 0);
      if (ordered) begin
        // duplicates now and then, saturating at the top of the range
        if ($urandom_range(0, 9) != 0) cur += longint'($urandom_range(1, gap_max));
        if (cur > longint'(POS_MAX)) cur = POS_MAX;
      end
    end
  endtask

  task automatic query_run(input int n);
    repeat (n)
      send_item(plti_pkg::KIND_QUERY, pick_query_pos(), plti_pkg::OFF_W'($urandom),
                1'($urandom));
  endtask

  task automatic note_mismatch(input string what, input answer_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: expected offset %0d valid %0b, got offset %0d valid %0b",
               $time, what, $signed(want.off), want.ok, $signed(result_offset_o),
               result_valid_o);
  endtask

  initial begin : result_checker
    int      hold_left;
    int      stall_left;
    bit      rx_gappy;
    answer_t want;
    hold_left  = 0;
    stall_left = 0;
    rx_gappy   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          note_mismatch("result with no query waiting", '0);
        end else begin
          want = pending_answers.pop_front();
          if (result_offset_o !== want.off || result_valid_o !== want.ok)
            note_mismatch("wrong lookup result", want);
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if ($urandom_range(0, 199) == 0) rx_gappy = !rx_gappy;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && rx_gappy && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int ep;
    int r;
    // empty table, unused kind, single entry, ends of the table
    plan(plti_pkg::KIND_QUERY,  '0, '0, 1'b0, 1'b1, '0, 1'b0);
    plan(KIND_UNUSED,           POS_MAX, OFF_MAX, 1'b1);
    plan(plti_pkg::KIND_APPEND, 32'sd100, OFF_MIN, 1'b1);
    plan(plti_pkg::KIND_QUERY,  POS_MAX, '0, 1'b0, 1'b1, OFF_MIN, 1'b1);
    plan(plti_pkg::KIND_APPEND, 32'sd100, OFF_MAX, 1'b1);
    plan(plti_pkg::KIND_QUERY,  32'sd100, '0, 1'b0, 1'b1, OFF_MIN, 1'b1);
    plan(plti_pkg::KIND_QUERY,  32'sd101, '0, 1'b0, 1'b1, OFF_MAX, 1'b1);
    plan(plti_pkg::KIND_APPEND, POS_MIN, '0, 1'b0);
    plan(plti_pkg::KIND_QUERY,  POS_MIN, '0, 1'b0, 1'b1, OFF_MIN, 1'b1);
    plan(plti_pkg::KIND_QUERY,  POS_MAX, '0, 1'b0, 1'b1, '0, 1'b0);
    // full position range as one span
    plan(plti_pkg::KIND_CLEAR,  '0);
    plan(plti_pkg::KIND_APPEND, POS_MIN, OFF_MIN, 1'b1);
    plan(plti_pkg::KIND_APPEND, POS_MAX, OFF_MAX, 1'b1);
    plan(plti_pkg::KIND_QUERY,  '0);
    plan(plti_pkg::KIND_QUERY,  POS_MAX - 32'sd1);
    // invalid neighbours
    plan(plti_pkg::KIND_CLEAR,  '0);
    plan(plti_pkg::KIND_APPEND, 32'sd0, 24'sd1000, 1'b1);
    plan(plti_pkg::KIND_APPEND, 32'sd1024, 24'sd2000, 1'b0);
    plan(plti_pkg::KIND_QUERY,  32'sd512, '0, 1'b0, 1'b1, '0, 1'b0);
    plan(plti_pkg::KIND_QUERY,  -32'sd5, '0, 1'b0, 1'b1, 24'sd1000, 1'b1);
    plan(plti_pkg::KIND_APPEND, 32'sd2048, -24'sd3000, 1'b1);
    plan(plti_pkg::KIND_QUERY,  32'sd1536, '0, 1'b0, 1'b1, '0, 1'b0);
    plan(plti_pkg::KIND_QUERY,  32'sd5000, '0, 1'b0, 1'b1, -24'sd3000, 1'b1);
    // negative slope, truncation toward zero
    plan(plti_pkg::KIND_CLEAR,  '0);
    plan(plti_pkg::KIND_APPEND, 32'sd0, 24'sd0, 1'b1);
    plan(plti_pkg::KIND_APPEND, 32'sd3, -24'sd10, 1'b1);
    plan(plti_pkg::KIND_QUERY,  32'sd1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i])
      send_item(directed_steps[i].kind, directed_steps[i].pos, directed_steps[i].off,
                directed_steps[i].ok, directed_steps[i].use_fixed,
                directed_steps[i].fixed_ans);

    ep = 0;
    while (items_sent < ITEMS) begin
      calm     = items_sent >= ITEMS - CALM_ITEMS;
      tx_gappy = $urandom_range(0, 2) != 0;
      if (ep == 6) hold_req = 1'b1;
      if (ep == 20 || ep == 60) begin
        // let the output side empty completely
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_answers.size() != 0);
      end
      if (ep == 10 || ep == 45) begin
        // full table plus dropped appends, then long walks
        send_item(plti_pkg::KIND_CLEAR, plti_pkg::POS_W'($urandom),
                  plti_pkg::OFF_W'($urandom), 1'($urandom));
        append_run(plti_pkg::DEPTH + 3, 1'b1);
        send_item(plti_pkg::KIND_QUERY, POS_MAX, '0, 1'b0);
        query_run(5);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_item(plti_pkg::KIND_CLEAR, plti_pkg::POS_W'($urandom),
                    plti_pkg::OFF_W'($urandom), 1'($urandom));
          append_run($urandom_range(1, 12), 1'b1);
          query_run($urandom_range(1, 8));
        end else if (r < 85) begin
          if (r < 80)
            send_item(plti_pkg::KIND_CLEAR, plti_pkg::POS_W'($urandom),
                      plti_pkg::OFF_W'($urandom), 1'($urandom));
          append_run($urandom_range(1, 10), 1'b0);
          query_run($urandom_range(1, 6));
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(2'($urandom), plti_pkg::POS_W'($urandom),
                      plti_pkg::OFF_W'($urandom), 1'($urandom));
        end
      end
      ep++;
    end

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
